FILE: rtl/core/rx2pf_pkg.sv
// ----------------------------------------------------------------------------
// rx2pf_pkg
// Shared types, constants and helpers of the regex infix-to-postfix unit.
// ----------------------------------------------------------------------------
package rx2pf_pkg;

  // Operator stack depth default
  localparam int unsigned StackDepthDefault = 32;

  // Configuration port geometry
  localparam int unsigned NumRegs = 8;
  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned CharW = 8;

  // Register reset values
  localparam logic [CharW-1:0] MaskReset = 8'd128;
  localparam logic [CharW-1:0] OpenReset = 8'd40;
  localparam logic [CharW-1:0] CloseReset = 8'd41;
  localparam logic [CharW-1:0] AndReset = 8'd38;
  localparam logic [CharW-1:0] OrReset = 8'd124;
  localparam logic [CharW-1:0] StarReset = 8'd42;
  localparam logic [CharW-1:0] PlusReset = 8'd43;
  localparam logic [CharW-1:0] QuestReset = 8'd63;

  typedef enum logic [2:0] {
    REG_MASK  = 3'd0,
    REG_OPEN  = 3'd1,
    REG_CLOSE = 3'd2,
    REG_AND   = 3'd3,
    REG_OR    = 3'd4,
    REG_STAR  = 3'd5,
    REG_PLUS  = 3'd6,
    REG_QUEST = 3'd7
  } reg_idx_e;

  // Operator kinds as kept on the stack
  typedef enum logic [2:0] {
    KIND_OPEN  = 3'd0,
    KIND_OR    = 3'd1,
    KIND_AND   = 3'd2,
    KIND_STAR  = 3'd3,
    KIND_PLUS  = 3'd4,
    KIND_QUEST = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    STATUS_OK              = 3'd0,
    STATUS_OVERFLOW        = 3'd1,
    STATUS_UNMATCHED_CLOSE = 3'd2,
    STATUS_UNMATCHED_OPEN  = 3'd3,
    STATUS_INVALID         = 3'd4
  } status_e;

  // Character classes
  typedef enum logic [2:0] {
    CLS_DATA,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OPER,
    CLS_INVALID
  } class_e;

  // Datapath commands from the controller
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_EMIT_DATA,
    CMD_PUSH,
    CMD_POP_EMIT,
    CMD_DROP_OPEN,
    CMD_FAULT,
    CMD_FLUSH_OPEN,
    CMD_FINISH
  } cmd_e;

  typedef struct packed {
    logic [CharW-1:0] mask;
    logic [CharW-1:0] open_code;
    logic [CharW-1:0] close_code;
    logic [CharW-1:0] and_code;
    logic [CharW-1:0] or_code;
    logic [CharW-1:0] star_code;
    logic [CharW-1:0] plus_code;
    logic [CharW-1:0] quest_code;
  } cfg_t;

  // Channel payloads
  typedef struct packed {
    logic [CharW-1:0] in_char;
    logic             in_last;
  } in_req_t;

  typedef struct packed {
    logic [CharW-1:0] out_char;
    logic             token_valid;
    logic             end_of_output;
    logic [2:0]       status;
  } out_rsp_t;

  typedef struct packed {
    cmd_e    op;
    status_e fault_status;
  } cmd_t;

  typedef struct packed {
    class_e cls;
    logic   last;
    logic   fault_seen;
    logic   stack_empty;
    logic   stack_full;
    logic   top_open;
    logic   top_outranks;
    logic   can_emit;
    logic   can_finish;
  } dp_status_t;

  // Binding strength: unary > and > or > open bracket
  function automatic logic [1:0] prec_of(kind_e kind);
    logic [1:0] p;
    case (kind)
      KIND_OPEN: p = 2'd0;
      KIND_OR:   p = 2'd1;
      KIND_AND:  p = 2'd2;
      default:   p = 2'd3;
    endcase
    return p;
  endfunction

  // Character code an operator leaves as
  function automatic logic [CharW-1:0] code_of(kind_e kind, cfg_t cfg);
    logic [CharW-1:0] c;
    case (kind)
      KIND_OR:    c = cfg.or_code;
      KIND_AND:   c = cfg.and_code;
      KIND_STAR:  c = cfg.star_code;
      KIND_PLUS:  c = cfg.plus_code;
      KIND_QUEST: c = cfg.quest_code;
      default:    c = cfg.open_code;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/rx2pf_stream_if.sv
// ----------------------------------------------------------------------------
// rx2pf_stream_if
// Valid/ready stream channel carrying one payload per request.
// ----------------------------------------------------------------------------
interface rx2pf_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/rx2pf_ram.sv
// ----------------------------------------------------------------------------
// rx2pf_ram
// Generic single-write, single-read RAM with registered, write-first read.
// ----------------------------------------------------------------------------
module rx2pf_ram #(
  parameter int unsigned Width = 3,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, new data on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/rx2pf_cfg_regs.sv
// ----------------------------------------------------------------------------
// rx2pf_cfg_regs
// APB register file holding the character codes and the translate mask.
// ----------------------------------------------------------------------------
module rx2pf_cfg_regs
  import rx2pf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[ApbAddrW-1:2]);

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mask       <= MaskReset;
      cfg_q.open_code  <= OpenReset;
      cfg_q.close_code <= CloseReset;
      cfg_q.and_code   <= AndReset;
      cfg_q.or_code    <= OrReset;
      cfg_q.star_code  <= StarReset;
      cfg_q.plus_code  <= PlusReset;
      cfg_q.quest_code <= QuestReset;
    end else if (wr_en) begin
      unique case (idx)
        REG_MASK:  cfg_q.mask       <= pwdata[CharW-1:0];
        REG_OPEN:  cfg_q.open_code  <= pwdata[CharW-1:0];
        REG_CLOSE: cfg_q.close_code <= pwdata[CharW-1:0];
        REG_AND:   cfg_q.and_code   <= pwdata[CharW-1:0];
        REG_OR:    cfg_q.or_code    <= pwdata[CharW-1:0];
        REG_STAR:  cfg_q.star_code  <= pwdata[CharW-1:0];
        REG_PLUS:  cfg_q.plus_code  <= pwdata[CharW-1:0];
        REG_QUEST: cfg_q.quest_code <= pwdata[CharW-1:0];
        default:   ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_MASK:  prdata[CharW-1:0] = cfg_q.mask;
      REG_OPEN:  prdata[CharW-1:0] = cfg_q.open_code;
      REG_CLOSE: prdata[CharW-1:0] = cfg_q.close_code;
      REG_AND:   prdata[CharW-1:0] = cfg_q.and_code;
      REG_OR:    prdata[CharW-1:0] = cfg_q.or_code;
      REG_STAR:  prdata[CharW-1:0] = cfg_q.star_code;
      REG_PLUS:  prdata[CharW-1:0] = cfg_q.plus_code;
      REG_QUEST: prdata[CharW-1:0] = cfg_q.quest_code;
      default:   prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/rx2pf_ctrl.sv
// ----------------------------------------------------------------------------
// rx2pf_ctrl
// Controller: sequences accept, operator pops, pushes, faults, flush and finish.
// ----------------------------------------------------------------------------
module rx2pf_ctrl
  import rx2pf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FLUSH,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  state_e done_st;  // where a finished character goes next

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign done_st    = status_i.last ? ST_FLUSH : ST_FINISH;
  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and command
  always_comb begin
    state_d = state_q;
    cmd_o.op = CMD_NONE;
    cmd_o.fault_status = STATUS_OK;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = CMD_LOAD;
          state_d  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.can_emit) begin
          if (status_i.fault_seen) begin
            state_d = ST_FINISH;
          end else begin
            case (status_i.cls)
              CLS_DATA: begin
                cmd_o.op = CMD_EMIT_DATA;
                state_d  = done_st;
              end
              CLS_OPEN: begin
                if (status_i.stack_full) begin
                  cmd_o.op = CMD_FAULT;
                  cmd_o.fault_status = STATUS_OVERFLOW;
                  state_d = ST_FINISH;
                end else begin
                  cmd_o.op = CMD_PUSH;
                  state_d  = done_st;
                end
              end
              CLS_CLOSE: begin
                if (status_i.stack_empty) begin
                  cmd_o.op = CMD_FAULT;
                  cmd_o.fault_status = STATUS_UNMATCHED_CLOSE;
                  state_d = ST_FINISH;
                end else if (!status_i.top_open) begin
                  cmd_o.op = CMD_POP_EMIT;
                end else begin
                  cmd_o.op = CMD_DROP_OPEN;
                  state_d  = done_st;
                end
              end
              CLS_OPER: begin
                if (!status_i.stack_empty && !status_i.top_open &&
                    status_i.top_outranks) begin
                  cmd_o.op = CMD_POP_EMIT;
                end else if (status_i.stack_full) begin
                  cmd_o.op = CMD_FAULT;
                  cmd_o.fault_status = STATUS_OVERFLOW;
                  state_d = ST_FINISH;
                end else begin
                  cmd_o.op = CMD_PUSH;
                  state_d  = done_st;
                end
              end
              default: begin
                cmd_o.op = CMD_FAULT;
                cmd_o.fault_status = STATUS_INVALID;
                state_d = ST_FINISH;
              end
            endcase
          end
        end
      end
      ST_FLUSH: begin
        if (status_i.can_emit) begin
          if (status_i.stack_empty) begin
            state_d = ST_FINISH;
          end else if (status_i.top_open) begin
            cmd_o.op = CMD_FLUSH_OPEN;
            state_d  = ST_FINISH;
          end else begin
            cmd_o.op = CMD_POP_EMIT;
          end
        end
      end
      ST_FINISH: begin
        if (status_i.can_finish) begin
          cmd_o.op = CMD_FINISH;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/rx2pf_dpath.sv
// ----------------------------------------------------------------------------
// rx2pf_dpath
// Datapath: character register, classifier, operator stack, result hold
// stage and output register.
// ----------------------------------------------------------------------------
module rx2pf_dpath
  import rx2pf_pkg::*;
#(
  parameter int unsigned StackDepth = StackDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  cmd_t       cmd_i,
  input  in_req_t    in_data_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output out_rsp_t   out_data_o,
  output dp_status_t status_o
);

  localparam int unsigned CntW  = $clog2(StackDepth + 1);
  localparam int unsigned AddrW = $clog2(StackDepth);

  // Current character
  logic [CharW-1:0] char_q, char_d;
  logic             last_q, last_d;
  logic             fault_q, fault_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  rd_ptr;

  // Result hold stage (the last result of a character waits here) and output
  out_rsp_t hold_q, hold_d;
  logic     hold_v_q, hold_v_d;
  out_rsp_t out_q, out_d;
  logic     out_v_q, out_v_d;

  class_e   cls;
  kind_e    item_kind;
  kind_e    top_kind;
  logic [2:0] top_raw;
  logic     is_letter;
  logic     out_free;
  logic     gen_v;
  out_rsp_t gen;
  logic     push_en;
  kind_e    push_kind;

  // Classifier: data first, then codes in fixed priority
  always_comb begin
    is_letter = ((char_q >= 8'h41) && (char_q <= 8'h5A)) ||
                ((char_q >= 8'h61) && (char_q <= 8'h7A)) ||
                ((char_q >= 8'h30) && (char_q <= 8'h39)) ||
                (char_q == 8'h5F);
    item_kind = KIND_OR;
    if (is_letter || ((char_q & cfg_i.mask) == cfg_i.mask)) begin
      cls = CLS_DATA;
    end else if (char_q == cfg_i.open_code) begin
      cls = CLS_OPEN;
    end else if (char_q == cfg_i.close_code) begin
      cls = CLS_CLOSE;
    end else if (char_q == cfg_i.or_code) begin
      cls = CLS_OPER;
    end else if (char_q == cfg_i.and_code) begin
      cls = CLS_OPER;
      item_kind = KIND_AND;
    end else if (char_q == cfg_i.star_code) begin
      cls = CLS_OPER;
      item_kind = KIND_STAR;
    end else if (char_q == cfg_i.plus_code) begin
      cls = CLS_OPER;
      item_kind = KIND_PLUS;
    end else if (char_q == cfg_i.quest_code) begin
      cls = CLS_OPER;
      item_kind = KIND_QUEST;
    end else begin
      cls = CLS_INVALID;
    end
  end

  // Operator stack; read port always tracks the entry under the next count
  rx2pf_ram #(
    .Width (3),
    .Depth (StackDepth)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (push_en),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (push_kind),
    .raddr_i (rd_ptr[AddrW-1:0]),
    .rdata_o (top_raw)
  );

  assign rd_ptr    = count_d - CntW'(1);
  assign top_kind  = kind_e'(top_raw);
  assign push_kind = (cls == CLS_OPEN) ? KIND_OPEN : item_kind;
  assign out_free  = !out_v_q || out_ready_i;

  // Command execution
  always_comb begin
    char_d   = char_q;
    last_d   = last_q;
    fault_d  = fault_q;
    count_d  = count_q;
    push_en  = 1'b0;
    gen_v    = 1'b0;
    gen      = '0;
    hold_d   = hold_q;
    hold_v_d = hold_v_q;
    out_d    = out_q;
    out_v_d  = out_v_q && !out_ready_i;

    unique case (cmd_i.op)
      CMD_LOAD: begin
        char_d = in_data_i.in_char;
        last_d = in_data_i.in_last;
      end
      CMD_EMIT_DATA: begin
        gen_v = 1'b1;
        gen.out_char = char_q;
        gen.token_valid = 1'b1;
      end
      CMD_PUSH: begin
        push_en = 1'b1;
        count_d = count_q + CntW'(1);
      end
      CMD_POP_EMIT: begin
        gen_v = 1'b1;
        gen.out_char = code_of(top_kind, cfg_i);
        gen.token_valid = 1'b1;
        count_d = count_q - CntW'(1);
      end
      CMD_DROP_OPEN: begin
        count_d = count_q - CntW'(1);
      end
      CMD_FAULT: begin
        gen_v = 1'b1;
        gen.status = cmd_i.fault_status;
        fault_d = 1'b1;
      end
      CMD_FLUSH_OPEN: begin
        gen_v = 1'b1;
        gen.status = STATUS_UNMATCHED_OPEN;
        count_d = count_q - CntW'(1);
      end
      CMD_FINISH: begin
        // Release the held result; the final one of an expression is marked
        if (hold_v_q) begin
          out_d = hold_q;
          out_d.end_of_output = last_q;
          out_v_d = 1'b1;
          hold_v_d = 1'b0;
        end else if (last_q) begin
          out_d = '0;
          out_d.end_of_output = 1'b1;
          out_v_d = 1'b1;
        end
        if (last_q) begin
          count_d = '0;
          fault_d = 1'b0;
        end
      end
      default: ;
    endcase

    // A new result pushes the held one onward
    if (gen_v) begin
      if (hold_v_q) begin
        out_d = hold_q;
        out_v_d = 1'b1;
      end
      hold_d = gen;
      hold_v_d = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_q  <= 1'b0;
      count_q  <= '0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      fault_q  <= fault_d;
      count_q  <= count_d;
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
    hold_q <= hold_d;
    out_q  <= out_d;
  end

  // Status to the controller
  always_comb begin
    status_o.cls          = cls;
    status_o.last         = last_q;
    status_o.fault_seen   = fault_q;
    status_o.stack_empty  = (count_q == '0);
    status_o.stack_full   = (count_q == CntW'(StackDepth));
    status_o.top_open     = (top_kind == KIND_OPEN);
    status_o.top_outranks = (prec_of(top_kind) >= prec_of(item_kind));
    status_o.can_emit     = !hold_v_q || out_free;
    status_o.can_finish   = out_free || (!hold_v_q && !last_q);
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/core/regex_infix_to_postfix_unit.sv
// ----------------------------------------------------------------------------
// regex_infix_to_postfix_unit
// Shunting-yard conversion of a normalized regular expression from infix to
// postfix order, one character per request, with an APB register file.
//
//   Channel  Dir  Handshake        Payload
//   in_i     in   valid/ready      in_char[7:0], in_last
//   out_o    out  valid/ready      out_char[7:0], token_valid,
//                                  end_of_output, status[2:0]
//   APB      in   psel/penable     8 byte-addressed 8-bit registers at 4*i
//
// A character is taken in the idle state; the execute state then pops one
// operator at a time before its own action, and the finish state closes it. A
// final character that does not fault passes the flush state, which pops the
// rest of the stack. The stack memory port gives one pop a cycle while results move on.
// Results leave through a hold stage and an output register; when both are
// full the sequencer waits. Reset clears the stack count, fault flag and
// handshake state at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module regex_infix_to_postfix_unit
  import rx2pf_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = StackDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  rx2pf_stream_if.sink        in_i,
  rx2pf_stream_if.source      out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  cfg_t       cfg;
  cmd_t       cmd;
  dp_status_t dp_status;
  logic       in_ready;

  // Register file
  rx2pf_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Controller
  rx2pf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  // Datapath
  rx2pf_dpath #(
    .StackDepth (STACK_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .in_data_i   (in_i.data),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data),
    .status_o    (dp_status)
  );

  assign in_i.ready = in_ready;

endmodule

FILE: rtl/core/rx2pf_checker.sv
// ----------------------------------------------------------------------------
// rx2pf_checker
// Port-level assertions on the result channel of the conversion unit.
// ----------------------------------------------------------------------------
module rx2pf_checker
  import rx2pf_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input out_rsp_t out_data_i
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  // Tokens never carry a fault code
  a_token_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.token_valid |-> out_data_i.status == STATUS_OK)
    else $error("token with fault status");

  // Non-token results carry no character
  a_empty_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.token_valid |-> out_data_i.out_char == '0)
    else $error("non-token result carries a character");

  // A bare marker only closes an expression
  a_bare_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.token_valid && out_data_i.status == STATUS_OK
      |-> out_data_i.end_of_output)
    else $error("bare marker without end of output");

endmodule

bind regex_infix_to_postfix_unit rx2pf_checker u_rx2pf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

FILE: tb/regex_infix_to_postfix_unit_test.sv
// ----------------------------------------------------------------------------
// regex_infix_to_postfix_unit_test
// Drives regular expression characters into the infix-to-postfix unit under
// several register settings and random stalls on both channels. A tracker
// class keeps its own operator stack, predicts the postfix tokens and checks
// every response in order.
// ----------------------------------------------------------------------------
module regex_infix_to_postfix_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rx2pf_pkg::*;

  localparam int unsigned StackDepth = StackDepthDefault;
  localparam int unsigned QuietCycles = 80;
  localparam int unsigned StallLimit = 4000;

  // Postfix tracker: own copy of registers, operator stack and fault flag
  class postfix_tracker;
    cfg_t        cfg;
    kind_e       op_stack[StackDepth];
    int unsigned op_count;
    bit          in_fault;
    out_rsp_t    pending_tokens[$];
    int unsigned error_count;

    function new();
      cfg = '{MaskReset, OpenReset, CloseReset, AndReset, OrReset, StarReset,
              PlusReset, QuestReset};
      op_count = 0;
      in_fault = 1'b0;
      error_count = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [CharW-1:0] v);
      case (idx)
        REG_MASK:  cfg.mask = v;
        REG_OPEN:  cfg.open_code = v;
        REG_CLOSE: cfg.close_code = v;
        REG_AND:   cfg.and_code = v;
        REG_OR:    cfg.or_code = v;
        REG_STAR:  cfg.star_code = v;
        REG_PLUS:  cfg.plus_code = v;
        default:   cfg.quest_code = v;
      endcase
    endfunction

    function int unsigned pending();
      return pending_tokens.size();
    endfunction

    function bit is_data(logic [CharW-1:0] c);
      if (c >= "A" && c <= "Z") return 1'b1;
      if (c >= "a" && c <= "z") return 1'b1;
      if (c >= "0" && c <= "9") return 1'b1;
      if (c == "_") return 1'b1;
      return (c & cfg.mask) == cfg.mask;
    endfunction

    // unary > and > or > open bracket
    function int unsigned rank(kind_e k);
      case (k)
        KIND_OPEN: return 0;
        KIND_OR:   return 1;
        KIND_AND:  return 2;
        default:   return 3;
      endcase
    endfunction

    function logic [CharW-1:0] token_code(kind_e k);
      case (k)
        KIND_OR:    return cfg.or_code;
        KIND_AND:   return cfg.and_code;
        KIND_STAR:  return cfg.star_code;
        KIND_PLUS:  return cfg.plus_code;
        KIND_QUEST: return cfg.quest_code;
        default:    return cfg.open_code;
      endcase
    endfunction

    function void add_token(logic [CharW-1:0] ch, logic valid, status_e st);
      pending_tokens.push_back('{out_char: ch, token_valid: valid, end_of_output: 1'b0,
                                 status: st});
    endfunction

    function kind_e pop_op();
      op_count--;
      return op_stack[op_count];
    endfunction

    function status_e push_op(kind_e k);
      if (op_count >= StackDepth) return STATUS_OVERFLOW;
      op_stack[op_count] = k;
      op_count++;
      return STATUS_OK;
    endfunction

    // One accepted character: append the tokens it produces
    function void convert_char(in_req_t req);
      int unsigned      base;
      status_e          st;
      kind_e            k;
      logic [CharW-1:0] c;
      bit               is_op;
      bit               found_open;
      base = pending_tokens.size();
      c = req.in_char;
      st = STATUS_OK;
      k = KIND_OPEN;
      if (!in_fault) begin
        if (is_data(c)) begin
          add_token(c, 1'b1, STATUS_OK);
        end else if (c == cfg.open_code) begin
          st = push_op(KIND_OPEN);
        end else if (c == cfg.close_code) begin
          while (op_count > 0 && op_stack[op_count-1] != KIND_OPEN)
            add_token(token_code(pop_op()), 1'b1, STATUS_OK);
          if (op_count == 0) st = STATUS_UNMATCHED_CLOSE;
          else op_count--;
        end else begin
          is_op = 1'b1;
          if (c == cfg.or_code) k = KIND_OR;
          else if (c == cfg.and_code) k = KIND_AND;
          else if (c == cfg.star_code) k = KIND_STAR;
          else if (c == cfg.plus_code) k = KIND_PLUS;
          else if (c == cfg.quest_code) k = KIND_QUEST;
          else is_op = 1'b0;
          if (!is_op) begin
            st = STATUS_INVALID;
          end else begin
            while (op_count > 0 && op_stack[op_count-1] != KIND_OPEN &&
                   rank(op_stack[op_count-1]) >= rank(k))
              add_token(token_code(pop_op()), 1'b1, STATUS_OK);
            st = push_op(k);
          end
        end
        if (st != STATUS_OK) begin
          add_token('0, 1'b0, st);
          in_fault = 1'b1;
        end else if (req.in_last) begin
          // flush; an open bracket left over ends the flush with a fault
          found_open = 1'b0;
          while (op_count > 0 && !found_open) begin
            k = pop_op();
            if (k == KIND_OPEN) begin
              add_token('0, 1'b0, STATUS_UNMATCHED_OPEN);
              found_open = 1'b1;
            end else begin
              add_token(token_code(k), 1'b1, STATUS_OK);
            end
          end
        end
      end
      if (req.in_last) begin
        if (pending_tokens.size() == base) add_token('0, 1'b0, STATUS_OK);
        pending_tokens[pending_tokens.size()-1].end_of_output = 1'b1;
        op_count = 0;
        in_fault = 1'b0;
      end
    endfunction

    function void check_token(out_rsp_t got);
      out_rsp_t want;
      if (pending_tokens.size() == 0) begin
        $error("unexpected response: out_char %0h token_valid %0b status %0d",
               got.out_char, got.token_valid, got.status);
        error_count++;
        return;
      end
      want = pending_tokens.pop_front();
      if (got.out_char !== want.out_char) begin
        $error("out_char: expected %0h, got %0h", want.out_char, got.out_char);
        error_count++;
      end
      if (got.token_valid !== want.token_valid) begin
        $error("token_valid: expected %0b, got %0b", want.token_valid, got.token_valid);
        error_count++;
      end
      if (got.end_of_output !== want.end_of_output) begin
        $error("end_of_output: expected %0b, got %0b", want.end_of_output,
               got.end_of_output);
        error_count++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        error_count++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  rx2pf_stream_if #(.payload_t(in_req_t))  req_ch ();
  rx2pf_stream_if #(.payload_t(out_rsp_t)) rsp_ch ();

  regex_infix_to_postfix_unit #(
    .STACK_DEPTH(StackDepth)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .out_o  (rsp_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  postfix_tracker   tracker;
  int unsigned      send_idle_pct;
  int unsigned      recv_idle_pct;
  int unsigned      items_sent;
  int unsigned      stall_cycles;
  logic [CharW-1:0] expr_q[$];

  // 12 ns clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Response side back-pressure
  always @(posedge clk_i) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Request/response monitor and stall watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_ch.valid && req_ch.ready) tracker.convert_char(req_ch.data);
      if (rsp_ch.valid && rsp_ch.ready) tracker.check_token(rsp_ch.data);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // One request; valid is left high after the handshake
  task automatic send_request(logic [CharW-1:0] c, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= '{in_char: c, in_last: last};
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_request(s[i], i == s.len() - 1);
  endtask

  task automatic send_expr_q();
    for (int i = 0; i < expr_q.size(); i++) send_request(expr_q[i], i == expr_q.size() - 1);
  endtask

  // Stop requesting and let every outstanding token drain
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (QuietCycles) @(posedge clk_i);
  endtask

  // Full register load over APB, setup then access phase per write
  task automatic load_config(logic [CharW-1:0] vals[NumRegs]);
    for (int i = 0; i < NumRegs; i++) begin
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ApbAddrW'({reg_idx_e'(i), 2'b00});
      pwdata <= ApbDataW'(vals[i]);
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      while (!pready) @(posedge clk_i);
      tracker.set_reg(reg_idx_e'(i), vals[i]);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [CharW-1:0] pick_data();
    case ($urandom_range(4))
      0:       return CharW'("A" + $urandom_range(25));
      1:       return CharW'("a" + $urandom_range(25));
      2:       return CharW'("0" + $urandom_range(9));
      3:       return "_";
      default: return CharW'($urandom_range(255)) | tracker.cfg.mask;
    endcase
  endfunction

  // Well-formed expression generator (nesting kept shallow)
  task automatic gen_term(int unsigned lvl);
    if (lvl < 3 && $urandom_range(99) < 25) begin
      expr_q.push_back(tracker.cfg.open_code);
      gen_expr(lvl + 1);
      expr_q.push_back(tracker.cfg.close_code);
    end else begin
      expr_q.push_back(pick_data());
    end
    if ($urandom_range(99) < 30) begin
      case ($urandom_range(2))
        0:       expr_q.push_back(tracker.cfg.star_code);
        1:       expr_q.push_back(tracker.cfg.plus_code);
        default: expr_q.push_back(tracker.cfg.quest_code);
      endcase
    end
  endtask

  task automatic gen_expr(int unsigned lvl);
    int unsigned alts;
    int unsigned terms;
    alts = (lvl < 3 && $urandom_range(3) == 0) ? 2 : 1;
    for (int a = 0; a < alts; a++) begin
      if (a > 0) expr_q.push_back(tracker.cfg.or_code);
      terms = $urandom_range(1, 3);
      for (int t = 0; t < terms; t++) begin
        if (t > 0) expr_q.push_back(tracker.cfg.and_code);
        gen_term(lvl);
      end
    end
  endtask

  // Nested brackets around one character, as deep as the caller asks
  task automatic send_deep(int unsigned levels);
    expr_q.delete();
    repeat (levels) expr_q.push_back(tracker.cfg.open_code);
    expr_q.push_back(pick_data());
    repeat (levels) expr_q.push_back(tracker.cfg.close_code);
    send_expr_q();
  endtask

  // Mostly well-formed expressions, some damaged ones, some raw noise
  task automatic send_random_seq();
    int unsigned pick;
    int unsigned pos;
    int unsigned len;
    pick = $urandom_range(99);
    expr_q.delete();
    if (pick < 85) begin
      gen_expr(0);
      if (pick >= 65) begin
        pos = $urandom_range(expr_q.size() - 1);
        case ($urandom_range(2))
          0: expr_q[pos] = CharW'($urandom_range(255));
          1: if (expr_q.size() > 1) expr_q.delete(pos);
          default: expr_q.insert(pos, ($urandom_range(1) == 1) ? tracker.cfg.close_code
                                                               : tracker.cfg.open_code);
        endcase
      end
      send_expr_q();
    end else begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++)
        send_request(CharW'($urandom_range(255)),
                     (i == len - 1) || ($urandom_range(99) < 15));
    end
  endtask

  initial begin
    logic [CharW-1:0] vals[NumRegs];
    int unsigned      phase_start;
    int unsigned      budget;
    tracker = new();
    rst_ni = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    items_sent = 0;
    stall_cycles = 0;
    send_idle_pct = 37;
    recv_idle_pct = 54;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: plain data, all operators with popping, unmatched close,
    // unmatched open with operators above it, invalid character followed by
    // a bare end marker, character extremes via the mask
    send_text("a");
    send_text("(a|b)*&c?&d+|e");
    send_text(")");
    send_text("a&(b|c");
    send_request(8'h00, 1'b0);
    send_request("b", 1'b1);
    send_request(8'hFF, 1'b0);
    send_request(8'h80, 1'b1);

    for (int p = 0; p < 6; p++) begin
      wait_idle();
      if (p < 2) begin
        send_idle_pct = 37;
        recv_idle_pct = 54;
      end else if (p < 4) begin
        send_idle_pct = 54;
        recv_idle_pct = 37;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      vals = '{MaskReset, OpenReset, CloseReset, AndReset, OrReset, StarReset,
               PlusReset, QuestReset};
      case (p)
        1: vals = '{{1'b1, 7'($urandom)}, "[", "]", ".", "/", "#", "%", "~"};
        2: vals = '{8'hFF, 8'h00, 8'hFE, 8'h01, 8'h7F, 8'h20, 8'h2E, 8'h5C};
        3: vals = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        4: begin
          // shared code: classification order decides
          vals[REG_MASK] = 8'h81;
          vals[REG_OR] = AndReset;
          vals[REG_STAR] = AndReset;
        end
        5: for (int i = 0; i < NumRegs; i++) vals[i] = CharW'($urandom_range(255));
        default: ;
      endcase
      load_config(vals);
      // overflow on a full stack, and depths around the limit
      if (p == 0) send_deep(StackDepth + 1);
      if (p == 2) send_deep($urandom_range(StackDepth - 2, StackDepth + 2));
      budget = (p == 3) ? 20 : 50;
      phase_start = items_sent;
      while (items_sent - phase_start < budget) send_random_seq();
    end

    wait_idle();
    if (tracker.error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/rx2pf_pkg.sv
rtl/core/rx2pf_stream_if.sv
rtl/core/rx2pf_ram.sv
rtl/core/rx2pf_cfg_regs.sv
rtl/core/rx2pf_ctrl.sv
rtl/core/rx2pf_dpath.sv
rtl/core/regex_infix_to_postfix_unit.sv
rtl/core/rx2pf_checker.sv
tb/regex_infix_to_postfix_unit_test.sv
